// File: sv/spo2_pkg.sv
// Package for the SpO2 ratio-of-ratios estimator: field structs, register codes,
// fixed-point constants. No dependencies.
package spo2_pkg;

  localparam int unsigned SampleBits = 18;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned LevelBits  = SampleBits + FracBits;
  localparam int unsigned EnergyBits = 62;
  localparam int unsigned RootBits   = 31;
  localparam int unsigned RBits      = 20;
  localparam int unsigned ProdBits   = RootBits + LevelBits;       // 65
  localparam int unsigned NumBits    = ProdBits + 16;              // 81
  localparam int unsigned DenShBits  = ProdBits + RBits;           // 85
  localparam logic [EnergyBits-1:0] EnergyMax = {EnergyBits{1'b1}};
  localparam logic [RBits-1:0]      RMax      = {RBits{1'b1}};
  localparam logic [20:0] KSlope  = 21'd1526989;
  localparam logic [23:0] KOffset = 24'd7164396;

  // register indexes
  localparam logic [1:0] RegDcWeight   = 2'd0;
  localparam logic [1:0] RegSpo2Weight = 2'd1;
  localparam logic [1:0] RegWindowLen  = 2'd2;
  localparam logic [1:0] RegFingerThr  = 2'd3;

  typedef struct packed {
    logic [SampleBits-1:0] red_sample;
    logic [SampleBits-1:0] ir_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] spo2_estimate;
    logic               finger_present;
  } out_item_t;

  // window-end work handed from front to back
  typedef struct packed {
    logic [EnergyBits-1:0] red_energy;
    logic [EnergyBits-1:0] ir_energy;
    logic [LevelBits-1:0]  red_level;
    logic [LevelBits-1:0]  ir_level;
    logic                  finger;
  } window_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_MUL_RED, FE_MUL_IR, FE_SQ_RED, FE_SQ_IR, FE_PUSH
  } fe_state_e;

  typedef enum logic [3:0] {
    BE_IDLE, BE_SQRT, BE_MUL0, BE_MUL1, BE_MUL2, BE_MUL3, BE_DIV,
    BE_SPO2, BE_FILT, BE_OUT
  } be_state_e;

endpackage

// File: sv/spo2_front.sv
// Front end: accepts sample beats, tracks DC levels and energies, detects window end.
// Depends on spo2_pkg.
module spo2_front import spo2_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  in_item_t             item_i,
  input  logic [15:0]          dc_weight_i,
  input  logic [9:0]           window_length_i,
  input  logic [SampleBits-1:0] finger_threshold_i,
  output logic                 push_o,
  output window_t              win_o,
  input  logic                 full_i
);

  fe_state_e state_q, state_d;
  in_item_t  item_q;
  logic [LevelBits-1:0]  red_lvl_q, red_lvl_d, ir_lvl_q, ir_lvl_d;
  logic [EnergyBits-1:0] red_en_q, red_en_d, ir_en_q, ir_en_d;
  logic [9:0]            cnt_q, cnt_d;
  logic                  last_q, last_d;

  logic [SampleBits-1:0] smp;
  logic [LevelBits-1:0]  lvl, s_full, nl, diff;
  logic [50:0]           blend;
  logic [25:0]           dev;
  logic [51:0]           sq;
  logic [EnergyBits-1:0] en, en_sum;
  logic [16:0]           inv_w;
  logic [10:0]           cnt_inc, len;

  // shared datapath: one level update or one square per cycle
  always_comb begin
    smp   = (state_q == FE_MUL_RED || state_q == FE_SQ_RED) ? item_q.red_sample
                                                            : item_q.ir_sample;
    lvl   = (state_q == FE_MUL_RED || state_q == FE_SQ_RED) ? red_lvl_q : ir_lvl_q;
    en    = (state_q == FE_SQ_RED) ? red_en_q : ir_en_q;
    s_full = {smp, {FracBits{1'b0}}};
    inv_w = 17'h10000 - {1'b0, dc_weight_i};
    blend = 51'(lvl) * 51'(dc_weight_i) + 51'(s_full) * 51'(inv_w) + 51'd32768;
    nl    = blend[16 +: LevelBits];
    diff  = (s_full >= lvl) ? s_full - lvl : lvl - s_full;
    dev   = diff[FracBits-8 +: 26];
    sq    = 52'(dev) * 52'(dev);
    en_sum = (62'(sq) > EnergyMax - en) ? EnergyMax : en + 62'(sq);
    cnt_inc = {1'b0, cnt_q} + 11'd1;
    len   = (window_length_i == 10'd0) ? 11'd1024 : {1'b0, window_length_i};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE:    if (valid_i) state_d = FE_MUL_RED;
      FE_MUL_RED: state_d = FE_MUL_IR;
      FE_MUL_IR:  state_d = FE_SQ_RED;
      FE_SQ_RED:  state_d = FE_SQ_IR;
      FE_SQ_IR:   state_d = last_d ? FE_PUSH : FE_IDLE;
      FE_PUSH:    if (!full_i) state_d = FE_IDLE;
      default:    state_d = FE_IDLE;
    endcase
  end

  always_comb begin
    red_lvl_d = red_lvl_q;
    ir_lvl_d  = ir_lvl_q;
    red_en_d  = red_en_q;
    ir_en_d   = ir_en_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    case (state_q)
      FE_MUL_RED: red_lvl_d = nl;
      FE_MUL_IR:  ir_lvl_d = nl;
      FE_SQ_RED:  red_en_d = en_sum;
      FE_SQ_IR: begin
        ir_en_d = en_sum;
        last_d  = (cnt_inc >= len);
        cnt_d   = last_d ? 10'd0 : cnt_inc[9:0];
      end
      FE_PUSH: if (!full_i) begin
        red_en_d = '0;
        ir_en_d  = '0;
      end
      default: ;
    endcase
  end

  assign stall_o = (state_q != FE_IDLE);
  assign push_o  = (state_q == FE_PUSH) && !full_i;
  always_comb begin
    win_o.red_energy = red_en_q;
    win_o.ir_energy  = ir_en_q;
    win_o.red_level  = red_lvl_q;
    win_o.ir_level   = ir_lvl_q;
    win_o.finger     = item_q.ir_sample > finger_threshold_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FE_IDLE;
      red_lvl_q <= '0;
      ir_lvl_q  <= '0;
      red_en_q  <= '0;
      ir_en_q   <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      red_lvl_q <= red_lvl_d;
      ir_lvl_q  <= ir_lvl_d;
      red_en_q  <= red_en_d;
      ir_en_q   <= ir_en_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FE_IDLE && valid_i) item_q <= item_i;
  end

endmodule

// File: sv/spo2_queue.sv
// Two-entry queue of window records between front and back.
// Depends on spo2_pkg.
module spo2_queue import spo2_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  window_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    avail_o,
  output window_t data_o
);

  window_t    mem_q [2];
  logic [1:0] wp_q, rp_q;

  assign full_o  = (wp_q[0] == rp_q[0]) && (wp_q[1] != rp_q[1]);
  assign avail_o = (wp_q != rp_q);
  assign data_o  = mem_q[rp_q[0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q[0]] <= data_i;
  end

endmodule

// File: sv/spo2_back.sv
// Back end: square roots, ratio division, SpO2 line and output filter; output register.
// Depends on spo2_pkg.
module spo2_back import spo2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  window_t     win_i,
  output logic        pop_o,
  input  logic [15:0] spo2_weight_i,
  output logic        valid_o,
  input  logic        stall_i,
  output out_item_t   item_o
);

  be_state_e state_q, state_d;
  logic [EnergyBits-1:0] rv_q, iv_q;        // remainders
  logic [RootBits-1:0]   rr_q, ir_q;        // roots
  logic [4:0]            it_q;
  logic [NumBits-1:0]    num_q;
  logic [ProdBits-1:0]   den_q;
  logic [RBits-1:0]      q_q;
  logic [47:0]           pp_q;              // partial product
  logic [LevelBits-1:0]  lr_q, li_q;
  logic                  finger_q;
  logic signed [25:0]    spo2_q;
  logic signed [15:0]    filt_q;
  out_item_t             out_q;
  logic                  ov_q;

  // one restoring root step per cycle per channel (two result bits)
  function automatic logic [EnergyBits+RootBits:0] sqrt_step(
    input logic [EnergyBits-1:0] v, input logic [RootBits-1:0] r, input logic [4:0] k);
    logic [63:0] trial;
    logic [63:0] rem;
    logic [RootBits-1:0] nr;
    begin
      rem   = {2'b00, v};
      trial = ({33'd0, r} << (k + 5'd1)) + (64'd1 << {k, 1'b0});
      nr    = r;
      if (rem >= trial) begin
        rem = rem - trial;
        nr  = r | (RootBits'(1) << k);
      end
      sqrt_step = {1'b0, rem[EnergyBits-1:0], nr};
    end
  endfunction

  logic [EnergyBits+RootBits:0] sr, si;
  logic [DenShBits-1:0] den_sh;
  logic [NumBits-1:0] num_sub;
  logic signed [49:0] acc;
  logic signed [25:0] xq;

  always_comb begin
    sr = sqrt_step(rv_q, rr_q, it_q);
    si = sqrt_step(iv_q, ir_q, it_q);
    den_sh  = DenShBits'(den_q) << it_q;
    num_sub = num_q - NumBits'(den_sh);
    acc = 50'(spo2_weight_i) * 50'(filt_q) * 50'sd256
        + 50'(17'h10000 - {1'b0, spo2_weight_i}) * 50'(spo2_q) + 50'sd8388608;
    xq  = 26'(acc >>> 24);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: if (avail_i) state_d = BE_SQRT;
      BE_SQRT: if (it_q == 5'd0) state_d = BE_MUL0;
      BE_MUL0: state_d = BE_MUL1;
      BE_MUL1: state_d = BE_MUL2;
      BE_MUL2: state_d = BE_MUL3;
      BE_MUL3: state_d = (den_q == '0) ? BE_SPO2 : BE_DIV;
      BE_DIV:  if (it_q == 5'd0) state_d = BE_SPO2;
      BE_SPO2: state_d = BE_FILT;
      BE_FILT: state_d = BE_OUT;
      BE_OUT:  if (!ov_q || !stall_i) state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  assign pop_o   = (state_q == BE_IDLE) && avail_i;
  assign valid_o = ov_q;
  assign item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      filt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_FILT) begin
        if (xq > 26'sd32767)       filt_q <= 16'sh7fff;
        else if (xq < -26'sd32768) filt_q <= -16'sh8000;
        else                       filt_q <= 16'(xq);
      end
      // load a new beat, or keep the held one while stalled
      ov_q <= (state_q == BE_OUT && (!ov_q || !stall_i)) || (ov_q && stall_i);
    end
  end

  // datapath: 31x34 products split into two 17-bit halves of the level
  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        rv_q <= win_i.red_energy;
        iv_q <= win_i.ir_energy;
        rr_q <= '0;
        ir_q <= '0;
        lr_q <= win_i.red_level;
        li_q <= win_i.ir_level;
        finger_q <= win_i.finger;
        it_q <= 5'd30;
      end
      BE_SQRT: begin
        rv_q <= sr[RootBits +: EnergyBits];
        rr_q <= sr[RootBits-1:0];
        iv_q <= si[RootBits +: EnergyBits];
        ir_q <= si[RootBits-1:0];
        it_q <= it_q - 5'd1;
      end
      BE_MUL0: pp_q <= 48'(rr_q) * 48'(li_q[16:0]);
      BE_MUL1: begin
        num_q <= NumBits'(ProdBits'(pp_q) + (ProdBits'(rr_q) * ProdBits'(li_q[33:17]) << 17))
                 << 16;
        pp_q  <= 48'(ir_q) * 48'(lr_q[16:0]);
      end
      BE_MUL2: den_q <= ProdBits'(pp_q) + (ProdBits'(ir_q) * ProdBits'(lr_q[33:17]) << 17);
      BE_MUL3: begin
        q_q  <= RMax;
        it_q <= 5'd19;
        if (den_q != '0 && DenShBits'(num_q) < (DenShBits'(den_q) << 20)) q_q <= '0;
        else it_q <= 5'd0;
      end
      BE_DIV: begin
        if (q_q != RMax || den_q == '0) begin
          if (DenShBits'(num_q) >= den_sh) begin
            num_q <= num_sub;
            q_q   <= q_q | (RBits'(1) << it_q);
          end
        end
        if (it_q != 5'd0) it_q <= it_q - 5'd1;
      end
      BE_SPO2: spo2_q <= $signed({2'b00, KOffset})
                       - $signed({1'b0, 25'((42'(KSlope) * 42'(q_q) + 42'd32768) >> 16)});
      BE_OUT: if (!ov_q || !stall_i) begin
        out_q.spo2_estimate  <= filt_q;
        out_q.finger_present <= finger_q;
      end
      default: ;
    endcase
  end

  // a result only leaves from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == BE_OUT) else $error("spurious result");
  // a popped window always starts the root loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BE_SQRT) else $error("pop without start");
  // the SpO2 step only follows the product or divide stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BE_SPO2 |-> $past(state_q) == BE_DIV || $past(state_q) == BE_MUL3)
    else $error("bad ratio sequencing");

endmodule

// File: sv/spo2_ratio_estimator.sv
// Channel  | dir | handshake           | payload
// in       | in  | in_valid / in_stall  | red_sample, ir_sample
// out      | out | out_valid / out_stall| spo2_estimate, finger_present
// cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
// Each sample beat passes through the front as two level updates and two squares, with a
// push state after the beat that closes a window, which waits while the queue is full.
// In the back a window end passes through 31 root steps, 4 product steps, up to 20
// divide steps and the filter; a two-entry queue absorbs it.
// in_stall_o is high while the front works on a beat; out_stall_i holds the output
// register, then the back, and once the queue is full the input as well.
// Reset clears levels, energies, count, filter state and all handshakes.
// Depends on spo2_pkg, spo2_front, spo2_queue, spo2_back.
module spo2_ratio_estimator import spo2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  logic [15:0] dc_w_q, sp_w_q;
  logic [9:0]  win_q;
  logic [SampleBits-1:0] thr_q;
  logic        push, full, pop, avail;
  window_t     wi, wo;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_w_q <= 16'd62259;
      sp_w_q <= 16'd45875;
      win_q  <= 10'd100;
      thr_q  <= 18'd30000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDcWeight:   dc_w_q <= cfg_data_i[15:0];
        RegSpo2Weight: sp_w_q <= cfg_data_i[15:0];
        RegWindowLen:  win_q  <= cfg_data_i[9:0];
        RegFingerThr:  thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spo2_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .stall_o(in_stall_o), .item_i(in_item_i),
    .dc_weight_i(dc_w_q), .window_length_i(win_q), .finger_threshold_i(thr_q),
    .push_o(push), .win_o(wi), .full_i(full));

  spo2_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wi), .full_o(full),
    .pop_i(pop), .avail_o(avail), .data_o(wo));

  spo2_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .win_i(wo), .pop_o(pop),
    .spo2_weight_i(sp_w_q), .valid_o(out_valid_o), .stall_i(out_stall_i),
    .item_o(out_item_o));

endmodule

// File: test/spo2_ratio_estimator_test.sv
// Self-checking testbench for spo2_ratio_estimator: directed table, then random windows
// under several register settings, every result checked by a predictor or a typed row.
// Depends on spo2_pkg and the estimator RTL.
module spo2_ratio_estimator_test;
  import spo2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 1000000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles = 400;
  localparam logic [63:0] EnergyCap = 64'h3FFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegDcWeight;
  logic [17:0] cfg_data_i = '0;

  spo2_ratio_estimator dut (.*);

  // predictor copy of registers and state
  logic [15:0] dc_w, spo2_w;
  logic [9:0]  win_len;
  logic [17:0] finger_thr;
  logic [33:0] red_dc, ir_dc;
  logic [61:0] red_sum, ir_sum;
  logic [9:0]  win_count;
  logic signed [15:0] est_state;

  out_item_t   pending_estimates[$];
  int          fail_count = 0;
  int          result_count = 0;
  int          beat_count = 0;
  bit          hold_req = 1'b0;
  longint unsigned cycle_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // DC level update, deviation squared into the channel's energy
  function automatic logic [33:0] dc_track(input logic [33:0] lvl, input logic [17:0] smp,
                                           inout logic [61:0] en);
    logic [63:0] s, nl, dev, sq, w;
    s = {46'b0, smp} << 16;
    w = {48'b0, dc_w};
    nl = ((64'(lvl) * w + s * (64'd65536 - w) + 64'd32768) >> 16) & 64'h3_FFFF_FFFF;
    dev = ((s >= nl) ? s - nl : nl - s) >> 8;
    sq = dev * dev;
    if (sq > EnergyCap - 64'(en)) en = EnergyCap[61:0];
    else en = en + sq[61:0];
    return nl[33:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] ratio_of_ratios();
    logic [127:0] num, den, q;
    num = (128'(floor_root(64'(red_sum))) * 128'(ir_dc)) << 16;
    den = 128'(floor_root(64'(ir_sum))) * 128'(red_dc);
    if (den == 0) return 64'(RMax);
    q = num / den;
    if (q >= (128'd1 << 20)) return 64'(RMax);
    return q[63:0];
  endfunction

  // one accepted sample beat; returns 1 with the estimate when the window closes
  function automatic bit window_step(input in_item_t it, output out_item_t res);
    logic [10:0] len, cnt;
    logic [63:0] r;
    longint sp, acc;
    red_dc = dc_track(red_dc, it.red_sample, red_sum);
    ir_dc = dc_track(ir_dc, it.ir_sample, ir_sum);
    len = (win_len == 0) ? 11'd1024 : {1'b0, win_len};
    cnt = {1'b0, win_count} + 11'd1;
    res = '0;
    if (cnt < len) begin
      win_count = cnt[9:0];
      return 1'b0;
    end
    r = ratio_of_ratios();
    sp = 64'sd7164396 - longint'((64'd1526989 * r + 64'd32768) >> 16);
    acc = longint'({48'b0, spo2_w}) * longint'(est_state) * 256
        + longint'(64'd65536 - {48'b0, spo2_w}) * sp + (64'sd1 <<< 23);
    acc = acc >>> 24;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    est_state = acc[15:0];
    res.spo2_estimate = est_state;
    res.finger_present = (it.ir_sample > finger_thr);
    red_sum = '0;
    ir_sum = '0;
    win_count = '0;
    return 1'b1;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [17:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 18'h0;
      1: return 18'h3FFFF;
      default: return 18'($urandom);
    endcase
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d estimates outstanding", $realtime, pending_estimates.size());
      $display("spo2_ratio_estimator_test failed");
      $finish;
    end
  end

  // output side: random stall, one long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      n = idle_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_estimates.size() == 0) begin
        $display("%0t: unexpected estimate %0d finger %0b", $realtime,
                 out_item_o.spo2_estimate, out_item_o.finger_present);
        fail_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (out_item_o.spo2_estimate !== want.spo2_estimate) begin
          $display("%0t: spo2_estimate expected %0d got %0d", $realtime,
                   want.spo2_estimate, out_item_o.spo2_estimate);
          fail_count++;
        end
        if (out_item_o.finger_present !== want.finger_present) begin
          $display("%0t: finger_present expected %0b got %0b", $realtime,
                   want.finger_present, out_item_o.finger_present);
          fail_count++;
        end
      end
    end
  end

  // offer one beat; predict at acceptance, a typed expectation overrides the predictor
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    int gap;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    beat_count++;
    if (window_step(it, res)) pending_estimates.push_back(typed ? typed_res : res);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDcWeight:   dc_w = val[15:0];
      RegSpo2Weight: spo2_w = val[15:0];
      RegWindowLen:  win_len = val[9:0];
      RegFingerThr:  finger_thr = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] dw, input logic [15:0] sw,
                          input logic [9:0] wl, input logic [17:0] thr);
    drain();
    write_reg(RegDcWeight, 18'(dw));
    write_reg(RegSpo2Weight, 18'(sw));
    write_reg(RegWindowLen, 18'(wl));
    write_reg(RegFingerThr, thr);
    cfg_valid_i <= 1'b0;
  endtask

  // random beats; extremes alternate when asked, for the largest deviations
  task automatic random_beats(input int n, input bit swing);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      if (swing) begin
        it.red_sample = i[0] ? 18'h3FFFF : 18'h0;
        it.ir_sample = i[0] ? 18'h0 : 18'h3FFFF;
      end else begin
        it.red_sample = rand_sample();
        it.ir_sample = rand_sample();
      end
      send_beat(it, 1'b0, '0);
    end
  endtask

  typedef struct {
    logic [17:0] red;
    logic [17:0] ir;
    bit          typed;
    logic signed [15:0] est;
    logic        finger;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    // dark sensor straight after reset: zero divisor, estimate pinned low
    '{18'h0, 18'h0, 1'b1, -16'sd32768, 1'b0},
    '{18'h3FFFF, 18'h3FFFF, 1'b0, 0, 1'b0},
    '{18'h3FFFF, 18'h0, 1'b0, 0, 1'b0},
    '{18'h0, 18'h3FFFF, 1'b0, 0, 1'b0},
    '{18'h20000, 18'h20000, 1'b0, 0, 1'b0},
    '{18'h20001, 18'h20000, 1'b0, 0, 1'b0},
    '{18'h1FFFF, 18'h1FFFF, 1'b0, 0, 1'b0},
    '{18'h15555, 18'h2AAAA, 1'b0, 0, 1'b0},
    '{18'h2AAAA, 18'h15555, 1'b0, 0, 1'b0},
    '{18'h00001, 18'h00001, 1'b0, 0, 1'b0},
    '{18'h3FFFE, 18'h3FFFE, 1'b0, 0, 1'b0},
    '{18'h12345, 18'h23456, 1'b0, 0, 1'b0},
    '{18'h0, 18'h0, 1'b0, 0, 1'b0},
    '{18'h3FFFF, 18'h3FFFF, 1'b0, 0, 1'b0},
    '{18'h0, 18'h0, 1'b0, 0, 1'b0}
  };

  initial begin
    in_item_t it;
    dc_w = 16'd62259;
    spo2_w = 16'd45875;
    win_len = 10'd100;
    finger_thr = 18'd30000;
    red_dc = '0;
    ir_dc = '0;
    red_sum = '0;
    ir_sum = '0;
    win_count = '0;
    est_state = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one estimate per beat, old estimate ignored, threshold at half scale
    set_regs(16'd62259, 16'd0, 10'd1, 18'h20000);
    foreach (directed_rows[i]) begin
      it.red_sample = directed_rows[i].red;
      it.ir_sample = directed_rows[i].ir;
      send_beat(it, directed_rows[i].typed,
                '{spo2_estimate: directed_rows[i].est, finger_present: directed_rows[i].finger});
    end

    // receiver holds off while beats keep coming, so the queue backs up into the input
    drain();
    hold_req = 1'b1;
    random_beats(30, 1'b0);

    set_regs(16'd0, 16'd65535, 10'd3, 18'h0);
    random_beats(90, 1'b1);
    set_regs(16'd65535, 16'd45875, 10'd2, 18'h3FFFF);
    random_beats(80, 1'b0);
    set_regs(16'($urandom), 16'($urandom), 10'd5, 18'($urandom));
    random_beats(100, 1'b0);
    // zero length leaves the window open, then it is shortened below the count
    set_regs(16'd62259, 16'd32768, 10'd0, 18'd30000);
    random_beats(20, 1'b0);
    set_regs(16'd62259, 16'd32768, 10'd4, 18'd30000);
    random_beats(80, 1'b0);
    for (int p = 0; p < 4; p++) begin
      set_regs(16'($urandom), 16'($urandom), 10'($urandom_range(1, 8)), 18'($urandom));
      random_beats(70, 1'b0);
    end
    set_regs(16'd62259, 16'd45875, 10'd100, 18'd30000);
    random_beats(100, 1'b0);

    drain();
    $display("Covered %0d sample beats and %0d estimates over eleven register settings,",
             beat_count, result_count);
    $display("including zero divisors, extreme swings, zero window length and a long hold-off.");
    if (fail_count == 0) begin
      $display("spo2_ratio_estimator_test passed");
    end else begin
      $display("spo2_ratio_estimator_test failed");
    end
    $finish;
  end

endmodule
